// File: hdl/video_register_port_with_vram_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the video register port
// Shared forms for concurrent checks on clocked logic with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef VIDEO_REGISTER_PORT_WITH_VRAM_ASSERT_SVH
`define VIDEO_REGISTER_PORT_WITH_VRAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VRP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/vrp_pkg.sv
// ---------------------------------------------------------------------------
// vrp_pkg
// Types, codes and address helpers shared by the video register port.
// ---------------------------------------------------------------------------
package vrp_pkg;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_e;

  // Register numbers within the port.
  localparam logic [2:0] RegCtrl   = 3'd0;
  localparam logic [2:0] RegMask   = 3'd1;
  localparam logic [2:0] RegStatus = 3'd2;
  localparam logic [2:0] RegOamAdr = 3'd3;
  localparam logic [2:0] RegOamDat = 3'd4;
  localparam logic [2:0] RegScroll = 3'd5;
  localparam logic [2:0] RegAddr   = 3'd6;
  localparam logic [2:0] RegData   = 3'd7;

  // Nametable mirroring modes; the undefined codes act as four-screen.
  localparam logic [2:0] MirVert = 3'd0;
  localparam logic [2:0] MirHorz = 3'd1;
  localparam logic [2:0] MirLow  = 3'd2;
  localparam logic [2:0] MirHigh = 3'd3;

  localparam logic [13:0] NameBase = 14'h2000;
  localparam logic [13:0] NameTop  = 14'h3EFF;

  localparam int SpriteMemBytes = 256;
  localparam int SpriteAw       = $clog2(SpriteMemBytes);
  localparam int ColorRamBytes  = 32;
  localparam int ColorAw        = $clog2(ColorRamBytes);

  localparam logic [7:0] GrayMask = 8'h30;

  typedef struct packed {
    logic                re;
    logic                we;
    logic [SpriteAw-1:0] addr;
    logic [7:0]          wdata;
  } spr_req_t;

  // Folds a video address onto the 4 KiB nametable space by mirroring mode.
  function automatic logic [11:0] name_index(input logic [13:0] a, input logic [2:0] mode);
    logic [11:0] r;
    unique case (mode)
      MirVert: r = {1'b0, a[10:0]};
      MirHorz: r = {1'b0, a[11], a[9:0]};
      MirLow:  r = {2'b00, a[9:0]};
      MirHigh: r = {2'b01, a[9:0]};
      default: r = a[11:0];
    endcase
    return r;
  endfunction

  // Entry zero of each sprite palette mirrors the matching background entry.
  function automatic logic [ColorAw-1:0] color_index(input logic [ColorAw-1:0] a);
    logic [ColorAw-1:0] r;
    r = a;
    if (a[4] && (a[1:0] == 2'b00)) begin
      r[4] = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/vrp_name_ram.sv
// ---------------------------------------------------------------------------
// vrp_name_ram
// Nametable RAM with registered read and a fill sweep to 0xFF after reset.
// ---------------------------------------------------------------------------
module vrp_name_ram #(
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [7:0]               wdata_i,
  output logic [7:0]               rdata_o,
  output logic                     busy_o
);
  localparam int Aw = $clog2(Depth);

  logic [7:0]    mem [Depth];
  logic [7:0]    rd_q;
  logic          busy_q;
  logic [Aw-1:0] cnt_q;
  logic          wr_en;
  logic [Aw-1:0] wr_addr;
  logic [7:0]    wr_data;

  // The sweep owns the write port until every entry holds 0xFF.
  assign wr_en   = busy_q || we_i;
  assign wr_addr = busy_q ? cnt_q : addr_i;
  assign wr_data = busy_q ? 8'hFF : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == Aw'(Depth - 1)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem[addr_i];
    end
  end

  assign rdata_o = rd_q;
  assign busy_o  = busy_q;

endmodule

// File: hdl/vrp_sprite_ram.sv
// ---------------------------------------------------------------------------
// vrp_sprite_ram
// Sprite attribute memory with registered read and per-entry valid bits.
// ---------------------------------------------------------------------------
module vrp_sprite_ram (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vrp_pkg::spr_req_t  req_i,
  output logic [7:0]         rdata_o
);
  import vrp_pkg::*;

  logic [7:0]                mem [SpriteMemBytes];
  logic [SpriteMemBytes-1:0] vld_q;
  logic [7:0]                rd_q;
  logic                      rd_vld_q;

  // An entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : 8'h00;

endmodule

// File: hdl/vrp_palette.sv
// ---------------------------------------------------------------------------
// vrp_palette
// Palette RAM in flip-flops with mirror folding and grayscale read masking.
// ---------------------------------------------------------------------------
module vrp_palette (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [vrp_pkg::ColorAw-1:0] addr_i,
  input  logic                        we_i,
  input  logic [7:0]                  wdata_i,
  input  logic                        gray_i,
  output logic [7:0]                  rdata_o
);
  import vrp_pkg::*;

  logic [7:0]         pal_q [ColorRamBytes];
  logic [ColorAw-1:0] idx;

  assign idx = color_index(addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ColorRamBytes; i++) begin
        pal_q[i] <= 8'h00;
      end
    end else if (we_i) begin
      pal_q[idx] <= wdata_i;
    end
  end

  assign rdata_o = pal_q[idx] & (gray_i ? GrayMask : 8'hFF);

endmodule

// File: hdl/video_register_port_with_vram.sv
// ---------------------------------------------------------------------------
// video_register_port_with_vram
// CPU-side register port of a tile video unit with its video memories.
// ---------------------------------------------------------------------------
// Each item is one CPU bus access (register read, register write, or a
// status-flag update) and yields exactly one result item, the byte left on
// the bus. The port sustains one item per clock cycle while the result
// output is not stalled; an item is held in the input register, where all
// decoding, register updates and memory accesses happen, and then sits in
// the result register until it is taken. Sprite and nametable reads use
// registered RAM ports; their data is picked up from the RAM output
// registers by forwarding muxes, so back-to-back accesses see each other's
// effects with no bubbles. After reset the nametable RAM is swept to 0xFF,
// one entry per cycle; in_stall_o stays high during the sweep, while the
// mirroring register can be written at any time through the APB port.
`include "video_register_port_with_vram_assert.svh"

module video_register_port_with_vram #(
  parameter int NAME_RAM_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  reg_index_i,
  input  logic [7:0]  wdata_i,
  // Result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  rdata_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vrp_pkg::*;

  localparam int          NameAw   = $clog2(NAME_RAM_BYTES);
  localparam logic [11:0] NameMask = 12'(NAME_RAM_BYTES - 1);

  // Configuration register: nametable mirroring mode.
  logic [2:0] mirror_q;

  // Input register stage.
  logic       x_valid_q;
  logic [1:0] x_cmd_q;
  logic [2:0] x_reg_q;
  logic [7:0] x_data_q;
  logic       x_adv;
  logic       in_acc;
  cmd_e       x_cmd;

  // Result register stage.
  logic       y_valid_q;
  logic [7:0] y_rdata_q, y_rdata_d;
  logic       y_spr_q, y_spr_d;

  // Architectural state of the port.
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;
  logic [2:0]  flags_q, flags_d;
  logic [14:0] v_q, v_d;
  logic [14:0] t_q, t_d;
  logic [2:0]  fine_x_q, fine_x_d;
  logic        toggle_q, toggle_d;
  logic [7:0]  oam_q, oam_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic        rb_mem_q, rb_mem_d;
  logic [7:0]  obus_q, obus_d;
  logic        ob_spr_q, ob_spr_d;

  // Memory interfaces.
  spr_req_t          spr_req;
  logic [7:0]        spr_data;
  logic              name_re, name_we, name_busy;
  logic [NameAw-1:0] name_addr;
  logic [7:0]        name_data;
  logic              pal_we;
  logic [7:0]        pal_data;

  logic [13:0] a;
  logic [13:0] a_next;
  logic [7:0]  ob_eff;
  logic [7:0]  rb_eff;

  // -------------------------------------------------------------------------
  // APB configuration port. One register, at paddr 0 to 3 (only paddr[2] is decoded); pready is tied high.
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {29'd0, mirror_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q <= 3'd0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      mirror_q <= pwdata[2:0];
    end
  end

  // -------------------------------------------------------------------------
  // Handshake. The input register advances whenever the result register is
  // empty or being emptied, so one item moves through per cycle.
  // -------------------------------------------------------------------------
  assign x_adv       = x_valid_q && (!y_valid_q || !out_stall_i);
  assign in_stall_o  = name_busy || (x_valid_q && !x_adv);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign x_cmd       = cmd_e'(x_cmd_q);
  assign out_valid_o = y_valid_q;

  // A sprite-data read leaves its byte in the sprite RAM output register,
  // which stays put until the next sprite read replaces the result register.
  assign rdata_o = y_spr_q ? spr_data : y_rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
      y_valid_q <= 1'b0;
      y_spr_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        x_valid_q <= 1'b1;
      end else if (x_adv) begin
        x_valid_q <= 1'b0;
      end
      if (x_adv) begin
        y_valid_q <= 1'b1;
        y_spr_q   <= y_spr_d;
      end else if (!out_stall_i) begin
        y_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_cmd_q  <= cmd_i;
      x_reg_q  <= reg_index_i;
      x_data_q <= wdata_i;
    end
    if (x_adv) begin
      y_rdata_q <= y_rdata_d;
    end
  end

  // -------------------------------------------------------------------------
  // Decode and update. The open-bus byte and read buffer may still live in
  // a RAM output register from an earlier item; the flags ob_spr_q and
  // rb_mem_q say where the current value is.
  // -------------------------------------------------------------------------
  assign a      = v_q[13:0];
  assign a_next = a + (ctrl_q[2] ? 14'd32 : 14'd1);
  assign ob_eff = ob_spr_q ? spr_data : obus_q;
  assign rb_eff = rb_mem_q ? name_data : rbuf_q;

  assign name_addr = NameAw'(name_index(a, mirror_q) & NameMask);

  always_comb begin
    ctrl_d   = ctrl_q;
    mask_d   = mask_q;
    flags_d  = flags_q;
    v_d      = v_q;
    t_d      = t_q;
    fine_x_d = fine_x_q;
    toggle_d = toggle_q;
    oam_d    = oam_q;
    rbuf_d   = rbuf_q;
    rb_mem_d = rb_mem_q;
    obus_d   = obus_q;
    ob_spr_d = ob_spr_q;
    spr_req  = '0;
    name_re  = 1'b0;
    name_we  = 1'b0;
    pal_we   = 1'b0;

    if (x_adv) begin
      unique case (x_cmd)
        CMD_READ: begin
          unique case (x_reg_q)
            RegStatus: begin
              obus_d      = {flags_q, ob_eff[4:0]};
              ob_spr_d    = 1'b0;
              flags_d[2]  = 1'b0;
              toggle_d    = 1'b0;
            end
            RegOamDat: begin
              spr_req.re   = 1'b1;
              spr_req.addr = oam_q;
              ob_spr_d     = 1'b1;
            end
            RegData: begin
              if (a <= NameTop) begin
                // Buffered read: the old buffer goes out, the nametable refills it (zero below it).
                obus_d   = rb_eff;
                ob_spr_d = 1'b0;
                if (a < NameBase) begin
                  rbuf_d   = 8'h00;
                  rb_mem_d = 1'b0;
                end else begin
                  name_re  = 1'b1;
                  rb_mem_d = 1'b1;
                end
              end else begin
                // Palette reads bypass the buffer delay.
                obus_d   = pal_data;
                ob_spr_d = 1'b0;
                rbuf_d   = pal_data;
                rb_mem_d = 1'b0;
              end
              v_d = {v_q[14], a_next};
            end
            default: begin
            end
          endcase
        end
        CMD_WRITE: begin
          obus_d   = x_data_q;
          ob_spr_d = 1'b0;
          unique case (x_reg_q)
            RegCtrl: begin
              ctrl_d       = x_data_q;
              t_d[11:10]   = x_data_q[1:0];
            end
            RegMask: begin
              mask_d = x_data_q;
            end
            RegOamAdr: begin
              oam_d = x_data_q;
            end
            RegOamDat: begin
              spr_req.we    = 1'b1;
              spr_req.addr  = oam_q;
              spr_req.wdata = x_data_q;
              oam_d         = oam_q + 8'd1;
            end
            RegScroll: begin
              if (!toggle_q) begin
                fine_x_d = x_data_q[2:0];
                t_d[4:0] = x_data_q[7:3];
              end else begin
                t_d[14:12] = x_data_q[2:0];
                t_d[9:5]   = x_data_q[7:3];
              end
              toggle_d = ~toggle_q;
            end
            RegAddr: begin
              if (!toggle_q) begin
                t_d[14]   = 1'b0;
                t_d[13:8] = x_data_q[5:0];
              end else begin
                t_d[7:0] = x_data_q;
                v_d      = {t_q[14:8], x_data_q};
              end
              toggle_d = ~toggle_q;
            end
            RegData: begin
              if (a >= NameBase) begin
                if (a <= NameTop) begin
                  name_we = 1'b1;
                end else begin
                  pal_we = 1'b1;
                end
              end
              v_d = {v_q[14], a_next};
            end
            default: begin
            end
          endcase
        end
        CMD_STATUS: begin
          flags_d = x_data_q[7:5];
        end
        default: begin
        end
      endcase
    end

    y_rdata_d = obus_d;
    y_spr_d   = ob_spr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= 8'h00;
      mask_q   <= 8'h00;
      flags_q  <= 3'd0;
      v_q      <= 15'd0;
      t_q      <= 15'd0;
      fine_x_q <= 3'd0;
      toggle_q <= 1'b0;
      oam_q    <= 8'h00;
      rbuf_q   <= 8'h00;
      rb_mem_q <= 1'b0;
      obus_q   <= 8'h00;
      ob_spr_q <= 1'b0;
    end else begin
      ctrl_q   <= ctrl_d;
      mask_q   <= mask_d;
      flags_q  <= flags_d;
      v_q      <= v_d;
      t_q      <= t_d;
      fine_x_q <= fine_x_d;
      toggle_q <= toggle_d;
      oam_q    <= oam_d;
      rbuf_q   <= rbuf_d;
      rb_mem_q <= rb_mem_d;
      obus_q   <= obus_d;
      ob_spr_q <= ob_spr_d;
    end
  end

  // -------------------------------------------------------------------------
  // Memories.
  // -------------------------------------------------------------------------
  vrp_sprite_ram u_sprite_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (spr_req),
    .rdata_o (spr_data)
  );

  vrp_name_ram #(
    .Depth (NAME_RAM_BYTES)
  ) u_name_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (name_re),
    .we_i    (name_we),
    .addr_i  (name_addr),
    .wdata_i (x_data_q),
    .rdata_o (name_data),
    .busy_o  (name_busy)
  );

  vrp_palette u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .addr_i  (a[ColorAw-1:0]),
    .we_i    (pal_we),
    .wdata_i (x_data_q),
    .gray_i  (mask_q[0]),
    .rdata_o (pal_data)
  );

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `VRP_ASSERT_SAME(a_no_item_during_sweep, clk_i, rst_ni, name_busy, !x_valid_q,
                   "item held while the nametable sweep is running")
  `VRP_ASSERT_NEXT(a_status_read_clears_toggle, clk_i, rst_ni,
                   x_adv && (x_cmd == CMD_READ) && (x_reg_q == RegStatus), !toggle_q,
                   "status read did not clear the write toggle")
  `VRP_ASSERT_NEXT(a_spr_result_stable, clk_i, rst_ni,
                   y_valid_q && y_spr_q && out_stall_i, $stable(spr_data),
                   "sprite read data moved under a stalled result")
  `VRP_ASSERT_NEXT(a_data_keeps_v14, clk_i, rst_ni,
                   x_adv && (x_reg_q == RegData) && ((x_cmd == CMD_READ) || (x_cmd == CMD_WRITE)),
                   v_q[14] == $past(v_q[14]),
                   "data port access changed bit 14 of the video address")

endmodule
